[hdl/hidrm_pkg.sv]
// Shared types and constants for the headphone impedance DC ramp meter.
package hidrm_pkg;

	// input item opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// configuration register indexes
	localparam logic CFG_CAL = 1'b0;
	localparam logic CFG_AUX = 1'b1;

	localparam logic [13:0] STEP_SIZE = 14'd100;
	localparam logic [13:0] LEVEL_A   = 14'd200;
	localparam logic [13:0] LEVEL_B   = 14'd2000;
	localparam logic [13:0] LEVEL_C   = 14'd8800;

	localparam logic [11:0] COEF_A = 12'd2417;
	localparam logic [11:0] COEF_B = 12'd967;
	localparam logic [11:0] COEF_C = 12'd879;
	localparam logic [26:0] RND_A  = 27'd256;
	localparam logic [26:0] RND_B  = 27'd1024;
	localparam logic [26:0] RND_C  = 27'd4096;
	localparam logic [16:0] MIN_A  = 17'd650;
	localparam logic [16:0] MIN_B  = 17'd150;

	localparam logic [15:0] AUX_CODE    = 16'd10000;
	localparam logic [15:0] OHMS_MAX    = 16'hFFFF;
	localparam logic [7:0]  CAL_RESET   = 8'd0;
	localparam logic [11:0] AUX_RESET   = 12'd4050;
	localparam logic [7:0]  CAL_NO_DIV  = 8'h80;

	// calibration divide: 24-bit dividend, 8-bit divisor
	localparam int DIV_BITS = 24;

	typedef struct packed {
		logic [1:0]  op;
		logic [11:0] adc_reading;
	} in_item_t;

	typedef struct packed {
		logic [13:0] dc_level;
		logic        want_reading;
		logic        busy_res;
		logic        done_res;
		logic [15:0] impedance;
	} out_item_t;

endpackage

[hdl/hidrm_div.sv]
// Restoring divider, one quotient bit per cycle, for the calibration scaling.
module hidrm_div import hidrm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [7:0]          divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);

	localparam int CW = $clog2(DIV_BITS);

	logic                busy_q;
	logic                done_q;
	logic [CW-1:0]       cnt_q;
	logic [7:0]          rem_q;
	logic [7:0]          dvs_q;
	logic [DIV_BITS-1:0] quo_q;

	logic [8:0] shifted;
	logic [8:0] diff;
	logic       ge;

	assign shifted = {rem_q, quo_q[DIV_BITS-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[7:0] : shifted[7:0];
			quo_q <= {quo_q[DIV_BITS-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/headphone_impedance_dc_ramp_meter.sv]
// Top level of the headphone impedance DC ramp meter: sequencer, converter, output register.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   in_data  (op, adc_reading)
//   out       source     out_valid / out_stall out_data (level, flags, impedance)
//   cfg       sink       cfg_we                cfg_index, cfg_data
//
// Start, tick and ordinary reading transfers load their result into the
// output register on the edge that accepts them. The fourth reading of a
// measurement at levels 200, 2000 or 8800 runs the converter (at 200 only if
// the mean is not above aux): the difference is formed on acceptance, then the
// multiply, the threshold/trim check, the bit-serial calibration divider and
// the post; the divider is skipped for a trim of 0 or -128 or a zero value.
// in_stall is high while a conversion runs or while the output register is
// full and stalled. Reset clears control and result state; cal and aux load their reset values.
module headphone_impedance_dc_ramp_meter import hidrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	typedef enum logic [2:0] {
		P_IDLE, P_BASE, P_RAMP, P_MEAS, P_DOWN
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_CHK, S_DIV, S_FIN
	} seq_t;

	// architectural state
	phase_t      phase_q;
	logic [13:0] level_q;
	logic [1:0]  cnt_q;
	logic [13:0] rsum_q;
	logic [13:0] base_q;
	logic [15:0] ohms_q;
	logic [7:0]  cal_q;
	logic [11:0] aux_q;

	// conversion sequencer
	seq_t        seq_q;
	logic [13:0] d_q;
	logic [26:0] prod_q;
	logic [15:0] res_q;

	out_item_t   out_q;
	logic        out_valid_q;

	logic accept;
	assign accept   = in_valid && !in_stall;
	assign in_stall = (seq_q != S_IDLE) || (out_valid_q && out_stall);

	// next state for one transfer
	phase_t      phase_nx;
	logic [13:0] level_nx;
	logic [1:0]  cnt_nx;
	logic [13:0] rsum_nx;
	logic [13:0] base_nx;
	logic [15:0] ohms_nx;
	logic        done_nx;
	logic        conv_go;
	logic [13:0] sum_add;

	assign sum_add = rsum_q + 14'(in_data.adc_reading);

	always_comb begin
		phase_nx = phase_q;
		level_nx = level_q;
		cnt_nx   = cnt_q;
		rsum_nx  = rsum_q;
		base_nx  = base_q;
		ohms_nx  = ohms_q;
		done_nx  = 1'b0;
		conv_go  = 1'b0;
		unique case (in_data.op)
			OP_START: begin
				phase_nx = P_BASE;
				level_nx = '0;
				cnt_nx   = '0;
				rsum_nx  = '0;
				base_nx  = '0;
			end
			OP_TICK: begin
				if (phase_q == P_RAMP) begin
					level_nx = level_q + STEP_SIZE;
					if (level_nx == LEVEL_A || level_nx == LEVEL_B || level_nx == LEVEL_C) begin
						phase_nx = P_MEAS;
						cnt_nx   = '0;
						rsum_nx  = '0;
					end
				end else if (phase_q == P_DOWN) begin
					level_nx = (level_q >= STEP_SIZE) ? level_q - STEP_SIZE : '0;
					if (level_nx == '0) begin
						phase_nx = P_IDLE;
						done_nx  = 1'b1;
					end
				end
			end
			OP_READ: begin
				if (phase_q == P_BASE || phase_q == P_MEAS) begin
					if (cnt_q == 2'd3) begin
						cnt_nx  = '0;
						rsum_nx = '0;
						if (phase_q == P_BASE) begin
							base_nx  = sum_add;
							phase_nx = P_RAMP;
						end else if (level_q == LEVEL_A && sum_add[13:2] > aux_q) begin
							// mean above the aux threshold: aux cable, no conversion
							ohms_nx  = AUX_CODE;
							phase_nx = P_DOWN;
						end else begin
							conv_go = 1'b1;
						end
					end else begin
						cnt_nx  = cnt_q + 1'b1;
						rsum_nx = sum_add;
					end
				end
			end
			default: ;
		endcase
	end

	// output register loads on a direct transfer or when a conversion posts
	logic out_load;
	assign out_load = (seq_q == S_IDLE && accept && !conv_go) || (seq_q == S_FIN);

	// converter datapath
	logic [11:0] coef;
	logic [26:0] rnd;
	logic [16:0] r_raw;
	logic [16:0] r_chk;
	logic [15:0] r_sat;
	logic [7:0]  dvs;
	logic        div_start;
	logic        div_done;
	logic [DIV_BITS-1:0] quo;

	always_comb begin
		priority if (level_q == LEVEL_A) begin
			coef  = COEF_A;
			rnd   = RND_A;
			r_raw = 17'(prod_q >> 9);
		end else if (level_q == LEVEL_B) begin
			coef  = COEF_B;
			rnd   = RND_B;
			r_raw = 17'(prod_q >> 11);
		end else begin
			coef  = COEF_C;
			rnd   = RND_C;
			r_raw = 17'(prod_q >> 13);
		end
	end

	always_comb begin
		r_chk = r_raw;
		if (level_q == LEVEL_A && r_raw < MIN_A)
			r_chk = '0;
		else if (level_q == LEVEL_B && r_raw < MIN_B)
			r_chk = '0;
	end

	assign r_sat     = r_chk[16] ? OHMS_MAX : r_chk[15:0];
	assign dvs       = 8'({cal_q[7], cal_q} + 9'd128);
	assign div_start = (seq_q == S_CHK) && (cal_q != '0) && (r_chk != '0)
		&& (cal_q != CAL_NO_DIV);

	hidrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({r_chk, 7'b0}),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_IDLE;
			level_q     <= '0;
			cnt_q       <= '0;
			rsum_q      <= '0;
			base_q      <= '0;
			ohms_q      <= '0;
			cal_q       <= CAL_RESET;
			aux_q       <= AUX_RESET;
			seq_q       <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAL: cal_q <= cfg_data[7:0];
					CFG_AUX: aux_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (seq_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= phase_nx;
						level_q <= level_nx;
						cnt_q   <= cnt_nx;
						rsum_q  <= rsum_nx;
						base_q  <= base_nx;
						ohms_q  <= ohms_nx;
						if (conv_go) begin
							d_q   <= (sum_add >= base_q) ? sum_add - base_q : '0;
							seq_q <= S_MUL;
						end else begin
							out_q <= '{dc_level: level_nx,
								want_reading: (phase_nx == P_BASE || phase_nx == P_MEAS),
								busy_res: (phase_nx != P_IDLE),
								done_res: done_nx,
								impedance: ohms_nx};
						end
					end
				end
				S_MUL: begin
					prod_q <= 27'(d_q) * 27'(coef) + rnd;
					seq_q  <= S_CHK;
				end
				S_CHK: begin
					if (div_start) begin
						seq_q <= S_DIV;
					end else begin
						// trim of -128 leaves no divisor: a nonzero value pins high
						res_q <= (cal_q == CAL_NO_DIV && r_chk != '0) ? OHMS_MAX : r_sat;
						seq_q <= S_FIN;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q <= (quo[DIV_BITS-1:16] != '0) ? OHMS_MAX : quo[15:0];
						seq_q <= S_FIN;
					end
				end
				S_FIN: begin
					ohms_q  <= res_q;
					phase_q <= (res_q != '0 || level_q == LEVEL_C) ? P_DOWN : P_RAMP;
					out_q   <= '{dc_level: level_q, want_reading: 1'b0, busy_res: 1'b1,
						done_res: 1'b0, impedance: res_q};
					seq_q   <= S_IDLE;
				end
				default: seq_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the output register is drained before a conversion posts its result
	a_conv_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != S_IDLE |-> !out_valid_q)
		else $error("output register full during conversion");

	a_done_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.done_res |-> out_q.dc_level == '0 && !out_q.busy_res)
		else $error("done flagged away from level zero");

	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == P_IDLE |-> level_q == '0)
		else $error("DC level driven while idle");

	a_conv_phase: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == S_MUL |-> phase_q == P_MEAS && $past(accept))
		else $error("conversion started outside a measurement");

endmodule
